// ===== sv/bmhpq_pkg.sv =====
package bmhpq_pkg;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    localparam logic [1:0] ST_ENQ   = 2'd0;
    localparam logic [1:0] ST_DEQ   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  prio_in;
        logic [15:0] handle_in;
    } bmhpq_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  prio_out;
        logic [15:0] handle_out;
        logic [6:0]  occupancy;
    } bmhpq_out_t;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] handle;
    } bmhpq_entry_t;

    typedef struct packed {
        logic idle;
        logic done;
    } bmhpq_ctrl_t;

endpackage

// ===== sv/bmhpq_engine.sv =====
module bmhpq_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  bmhpq_pkg::bmhpq_in_t   req,
    input  logic                   take,
    output bmhpq_pkg::bmhpq_ctrl_t ctrl,
    output bmhpq_pkg::bmhpq_out_t  res
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = IW + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DQ_LAST,
        S_DQ_LOAD,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_DONE
    } state_t;

    state_t                   state_reg;
    logic [IW-1:0]            pos_reg;
    logic [CW-1:0]            count_reg;
    bmhpq_pkg::bmhpq_entry_t  cur_reg;
    bmhpq_pkg::bmhpq_entry_t  best_reg;
    logic                     left_sel_reg;
    bmhpq_pkg::bmhpq_out_t    res_reg;
    bmhpq_pkg::bmhpq_entry_t  rd_data_reg;

    bmhpq_pkg::bmhpq_entry_t  heap_mem [CAPACITY];

    logic [IW-1:0]            rd_addr;
    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    bmhpq_pkg::bmhpq_entry_t  wr_data;

    logic [7:0]               cmp_a;
    logic [7:0]               cmp_b;
    logic                     cmp_lt;

    logic [IW-1:0]            parent_idx;
    logic [XW-1:0]            lchild_idx;
    logic [XW-1:0]            rchild_idx;
    logic                     left_ok;
    logic                     right_ok;
    logic [CW-1:0]            count_inc;
    logic [CW-1:0]            count_dec;

    assign parent_idx = IW'((pos_reg - 1'b1) >> 1);
    assign lchild_idx = {1'b0, pos_reg, 1'b1};
    assign rchild_idx = lchild_idx + 1'b1;
    assign left_ok    = lchild_idx < XW'(count_reg);
    assign right_ok   = rchild_idx < XW'(count_reg);
    assign count_inc  = count_reg + 1'b1;
    assign count_dec  = count_reg - 1'b1;

    assign cmp_lt = cmp_a < cmp_b;

    always_comb
    begin
        cmp_a = rd_data_reg.prio;
        cmp_b = cur_reg.prio;
        unique case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = cur_reg.prio;
                cmp_b = rd_data_reg.prio;
            end
            S_DN_CMP:
            begin
                cmp_b = best_reg.prio;
            end
            default:
            begin
                cmp_a = rd_data_reg.prio;
                cmp_b = cur_reg.prio;
            end
        endcase
    end

    always_comb
    begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = cur_reg;
        unique case (state_reg)
            S_UP_RD:
            begin
                rd_addr = parent_idx;
                wr_en   = (pos_reg == '0);
            end
            S_UP_CMP:
            begin
                wr_en   = 1'b1;
                wr_data = cmp_lt ? rd_data_reg : cur_reg;
            end
            S_DQ_LAST:
            begin
                rd_addr = IW'(count_reg);
            end
            S_DN_L:
            begin
                rd_addr = lchild_idx[IW-1:0];
                wr_en   = !left_ok;
            end
            S_DN_R:
            begin
                rd_addr = rchild_idx[IW-1:0];
            end
            S_DN_CMP:
            begin
                wr_en = 1'b1;
                priority if (right_ok && cmp_lt)
                begin
                    wr_data = rd_data_reg;
                end
                else if (left_sel_reg)
                begin
                    wr_data = best_reg;
                end
                else
                begin
                    wr_data = cur_reg;
                end
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= heap_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pos_reg      <= '0;
            left_sel_reg <= 1'b0;
            cur_reg      <= '0;
            best_reg     <= '0;
            res_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        res_reg.prio_out   <= '0;
                        res_reg.handle_out <= '0;
                        cur_reg.prio       <= req.prio_in;
                        cur_reg.handle     <= req.handle_in;
                        if (req.req_type == bmhpq_pkg::REQ_ENQ)
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                res_reg.status    <= bmhpq_pkg::ST_FULL;
                                res_reg.occupancy <= 7'(count_reg);
                                state_reg         <= S_DONE;
                            end
                            else
                            begin
                                res_reg.status    <= bmhpq_pkg::ST_ENQ;
                                res_reg.occupancy <= 7'(count_inc);
                                pos_reg           <= IW'(count_reg);
                                count_reg         <= count_inc;
                                state_reg         <= S_UP_RD;
                            end
                        end
                        else
                        begin
                            if (count_reg == '0)
                            begin
                                res_reg.status    <= bmhpq_pkg::ST_EMPTY;
                                res_reg.occupancy <= 7'(count_reg);
                                state_reg         <= S_DONE;
                            end
                            else
                            begin
                                res_reg.status    <= bmhpq_pkg::ST_DEQ;
                                res_reg.occupancy <= 7'(count_dec);
                                count_reg         <= count_dec;
                                state_reg         <= S_DQ_LAST;
                            end
                        end
                    end
                end
                S_UP_RD:
                begin
                    state_reg <= (pos_reg == '0) ? S_DONE : S_UP_CMP;
                end
                S_UP_CMP:
                begin
                    if (cmp_lt)
                    begin
                        pos_reg   <= parent_idx;
                        state_reg <= S_UP_RD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DQ_LAST:
                begin
                    res_reg.prio_out   <= rd_data_reg.prio;
                    res_reg.handle_out <= rd_data_reg.handle;
                    state_reg          <= S_DQ_LOAD;
                end
                S_DQ_LOAD:
                begin
                    cur_reg   <= rd_data_reg;
                    pos_reg   <= '0;
                    state_reg <= S_DN_L;
                end
                S_DN_L:
                begin
                    state_reg <= left_ok ? S_DN_R : S_DONE;
                end
                S_DN_R:
                begin
                    if (cmp_lt)
                    begin
                        best_reg     <= rd_data_reg;
                        left_sel_reg <= 1'b1;
                    end
                    else
                    begin
                        best_reg     <= cur_reg;
                        left_sel_reg <= 1'b0;
                    end
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    priority if (right_ok && cmp_lt)
                    begin
                        pos_reg   <= rchild_idx[IW-1:0];
                        state_reg <= S_DN_L;
                    end
                    else if (left_sel_reg)
                    begin
                        pos_reg   <= lchild_idx[IW-1:0];
                        state_reg <= S_DN_L;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign ctrl.idle = (state_reg == S_IDLE);
    assign ctrl.done = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

// ===== sv/binary_min_heap_priority_queue_top.sv =====
// channel | signals                      | payload
// --------+------------------------------+------------------------------------
// req     | req_valid / req_ready        | req : bmhpq_in_t  (one request)
// rsp     | rsp_valid / rsp_ready        | rsp : bmhpq_out_t (one per request)
//
// A full enqueue or an empty dequeue goes straight to done. An enqueue sifts
// up, reading the parent and comparing per level; a dequeue moves the last
// entry to the root and sifts down, reading both children per level. Reset
// empties the heap, no clearing pass. req_ready is high only while idle; a
// finished transaction holds in the engine until the rsp register is free,
// which holds while rsp_ready is low.
module binary_min_heap_priority_queue_top #(
    parameter int CAPACITY = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  bmhpq_pkg::bmhpq_in_t  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output bmhpq_pkg::bmhpq_out_t rsp
);

    bmhpq_pkg::bmhpq_ctrl_t ctrl;
    bmhpq_pkg::bmhpq_out_t  eng_res;
    bmhpq_pkg::bmhpq_out_t  rsp_reg;
    logic                   rsp_valid_reg;
    logic                   take;
    logic                   start;

    assign req_ready = ctrl.idle;
    assign start     = req_valid && ctrl.idle;
    assign take      = ctrl.done && (!rsp_valid_reg || rsp_ready);

    bmhpq_engine #(
        .CAPACITY(CAPACITY)
    ) u_engine (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .req  (req),
        .take (take),
        .ctrl (ctrl),
        .res  (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (take)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_reg       <= eng_res;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
